/* hdl/sit_pkg.sv */
`default_nettype none

package sit_pkg;

    localparam int SIT_FIELD_W = 16;
    localparam int SIT_RAW_W   = 32;

    localparam int SIT_N_COORD = 8;
    localparam int SIT_N_DIFF  = 10;
    localparam int SIT_N_PROD  = 10;
    localparam int SIT_N_CROSS = 5;

    // coordinate slots
    localparam int C_A0X = 0;
    localparam int C_A0Y = 1;
    localparam int C_A1X = 2;
    localparam int C_A1Y = 3;
    localparam int C_B0X = 4;
    localparam int C_B0Y = 5;
    localparam int C_B1X = 6;
    localparam int C_B1Y = 7;

    // difference slots: direction of a, direction of b, b0-a0, b1-a0, a1-b0
    localparam int D_AX  = 0;
    localparam int D_AY  = 1;
    localparam int D_BX  = 2;
    localparam int D_BY  = 3;
    localparam int D_E0X = 4;
    localparam int D_E0Y = 5;
    localparam int D_E1X = 6;
    localparam int D_E1Y = 7;
    localparam int D_FX  = 8;
    localparam int D_FY  = 9;

    // cross products: cross k = prod[2k] - prod[2k+1]
    localparam int X_DIR = 0;
    localparam int X_C1  = 1;
    localparam int X_C2  = 2;
    localparam int X_C3  = 3;
    localparam int X_C4  = 4;

    localparam int SIT_MUL_L [SIT_N_PROD] = '{
        D_AX, D_AY,
        D_AX, D_AY,
        D_AX, D_AY,
        D_BY, D_BX,
        D_BX, D_BY
    };

    localparam int SIT_MUL_R [SIT_N_PROD] = '{
        D_BY, D_BX,
        D_E0Y, D_E0X,
        D_E1Y, D_E1X,
        D_E0X, D_E0Y,
        D_FY, D_FX
    };

    typedef struct packed {
        logic zero;
        logic neg;
    } t_sit_sgn;

    typedef struct packed {
        logic b0_on_a;
        logic b1_on_a;
        logic a0_on_b;
        logic a1_on_b;
    } t_sit_box;

endpackage

`default_nettype wire

/* hdl/sit_diff.sv */
`default_nettype none

module sit_diff #(
    parameter int CW = 16
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [sit_pkg::SIT_FIELD_W-1:0]    i_coord [sit_pkg::SIT_N_COORD],
    output logic signed [CW:0]                 o_diff  [sit_pkg::SIT_N_DIFF],
    output sit_pkg::t_sit_box                  o_box
);
    import sit_pkg::*;

    logic [SIT_RAW_W-1:0]  w_raw   [SIT_N_COORD];
    logic signed [CW-1:0]  w_c     [SIT_N_COORD];
    logic signed [CW:0]    n_diff  [SIT_N_DIFF];
    logic signed [CW:0]    r_diff  [SIT_N_DIFF];
    t_sit_box              n_box;
    t_sit_box              r_box;

    function automatic logic f_between(
        input logic signed [CW-1:0] p,
        input logic signed [CW-1:0] s0,
        input logic signed [CW-1:0] s1
    );
        return ((p >= s0) && (p <= s1)) || ((p >= s1) && (p <= s0));
    endfunction

    always_comb begin
        for (int k = 0; k < SIT_N_COORD; k++) begin
            w_raw[k] = SIT_RAW_W'(i_coord[k]);
            w_c[k]   = signed'(w_raw[k][CW-1:0]);
        end

        n_diff[D_AX]  = (CW+1)'(w_c[C_A1X]) - (CW+1)'(w_c[C_A0X]);
        n_diff[D_AY]  = (CW+1)'(w_c[C_A1Y]) - (CW+1)'(w_c[C_A0Y]);
        n_diff[D_BX]  = (CW+1)'(w_c[C_B1X]) - (CW+1)'(w_c[C_B0X]);
        n_diff[D_BY]  = (CW+1)'(w_c[C_B1Y]) - (CW+1)'(w_c[C_B0Y]);
        n_diff[D_E0X] = (CW+1)'(w_c[C_B0X]) - (CW+1)'(w_c[C_A0X]);
        n_diff[D_E0Y] = (CW+1)'(w_c[C_B0Y]) - (CW+1)'(w_c[C_A0Y]);
        n_diff[D_E1X] = (CW+1)'(w_c[C_B1X]) - (CW+1)'(w_c[C_A0X]);
        n_diff[D_E1Y] = (CW+1)'(w_c[C_B1Y]) - (CW+1)'(w_c[C_A0Y]);
        n_diff[D_FX]  = (CW+1)'(w_c[C_A1X]) - (CW+1)'(w_c[C_B0X]);
        n_diff[D_FY]  = (CW+1)'(w_c[C_A1Y]) - (CW+1)'(w_c[C_B0Y]);

        n_box.b0_on_a = f_between(w_c[C_B0X], w_c[C_A0X], w_c[C_A1X]) &&
                        f_between(w_c[C_B0Y], w_c[C_A0Y], w_c[C_A1Y]);
        n_box.b1_on_a = f_between(w_c[C_B1X], w_c[C_A0X], w_c[C_A1X]) &&
                        f_between(w_c[C_B1Y], w_c[C_A0Y], w_c[C_A1Y]);
        n_box.a0_on_b = f_between(w_c[C_A0X], w_c[C_B0X], w_c[C_B1X]) &&
                        f_between(w_c[C_A0Y], w_c[C_B0Y], w_c[C_B1Y]);
        n_box.a1_on_b = f_between(w_c[C_A1X], w_c[C_B0X], w_c[C_B1X]) &&
                        f_between(w_c[C_A1Y], w_c[C_B0Y], w_c[C_B1Y]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
            r_box  <= n_box;
        end
    end

    assign o_diff = r_diff;
    assign o_box  = r_box;

endmodule

`default_nettype wire

/* hdl/sit_mul.sv */
`default_nettype none

module sit_mul #(
    parameter int CW = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [CW:0]         i_diff [sit_pkg::SIT_N_DIFF],
    input  sit_pkg::t_sit_box          i_box,
    output logic signed [2*CW+1:0]     o_prod [sit_pkg::SIT_N_PROD],
    output sit_pkg::t_sit_box          o_box
);
    import sit_pkg::*;

    localparam int PW = 2 * CW + 2;

    logic signed [PW-1:0] n_prod [SIT_N_PROD];
    logic signed [PW-1:0] r_prod [SIT_N_PROD];
    t_sit_box             r_box;

    always_comb begin
        for (int k = 0; k < SIT_N_PROD; k++) begin
            n_prod[k] = PW'(i_diff[SIT_MUL_L[k]]) * PW'(i_diff[SIT_MUL_R[k]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_box  <= i_box;
        end
    end

    assign o_prod = r_prod;
    assign o_box  = r_box;

endmodule

`default_nettype wire

/* hdl/sit_sign.sv */
`default_nettype none

module sit_sign #(
    parameter int CW = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [2*CW+1:0]     i_prod [sit_pkg::SIT_N_PROD],
    input  sit_pkg::t_sit_box          i_box,
    output sit_pkg::t_sit_sgn          o_sgn  [sit_pkg::SIT_N_CROSS],
    output sit_pkg::t_sit_box          o_box
);
    import sit_pkg::*;

    localparam int PW = 2 * CW + 2;

    logic signed [PW:0] w_x   [SIT_N_CROSS];
    t_sit_sgn           n_sgn [SIT_N_CROSS];
    t_sit_sgn           r_sgn [SIT_N_CROSS];
    t_sit_box           r_box;

    always_comb begin
        for (int k = 0; k < SIT_N_CROSS; k++) begin
            w_x[k]        = (PW+1)'(i_prod[2*k]) - (PW+1)'(i_prod[2*k+1]);
            n_sgn[k].zero = (w_x[k] == '0);
            n_sgn[k].neg  = w_x[k][PW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sgn <= n_sgn;
            r_box <= i_box;
        end
    end

    assign o_sgn = r_sgn;
    assign o_box = r_box;

endmodule

`default_nettype wire

/* hdl/segment_intersection_test_unit.sv */
// Segment intersection test, one pair of segments per transfer.
// Input channel: i_valid / o_stall with eight coordinate ports, the start
// and end points of the first and second segment, two's complement; only the
// low COORD_WIDTH bits of each are used, sign-extended from the top one.
// Output channel: o_valid / i_stall with o_hit, one result per input.
// Non-parallel segments hit only on a proper crossing (touching is a miss);
// parallel segments hit when collinear and overlapping, ends included.
// A transfer passes the difference, multiplier, sign and decision
// registers in order. Throughput: one transfer per cycle while the
// receiver does not stall; every stage is registered, and the
// multiplier stage does all ten cross-product terms in parallel.
// Reset clears all stage valid bits; the pipe is empty and o_stall is low.
// When the receiver stalls, the result holds on o_hit and stages upstream
// keep filling empty slots; o_stall rises only once every stage is full.
`default_nettype none

module segment_intersection_test_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [sit_pkg::SIT_FIELD_W-1:0] i_first_start_x,
    input  logic [sit_pkg::SIT_FIELD_W-1:0] i_first_start_y,
    input  logic [sit_pkg::SIT_FIELD_W-1:0] i_first_end_x,
    input  logic [sit_pkg::SIT_FIELD_W-1:0] i_first_end_y,
    input  logic [sit_pkg::SIT_FIELD_W-1:0] i_second_start_x,
    input  logic [sit_pkg::SIT_FIELD_W-1:0] i_second_start_y,
    input  logic [sit_pkg::SIT_FIELD_W-1:0] i_second_end_x,
    input  logic [sit_pkg::SIT_FIELD_W-1:0] i_second_end_y,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_hit
);
    import sit_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int N_STG = 4;

    logic [SIT_FIELD_W-1:0] w_coord [SIT_N_COORD];
    logic signed [CW:0]     w_diff  [SIT_N_DIFF];
    logic signed [2*CW+1:0] w_prod  [SIT_N_PROD];
    t_sit_sgn               w_sgn   [SIT_N_CROSS];
    t_sit_box               w_box1;
    t_sit_box               w_box2;
    t_sit_box               w_box3;

    logic [N_STG-1:0] w_en;
    logic [N_STG-1:0] n_vld;
    logic [N_STG-1:0] r_vld;
    logic             w_par_hit;
    logic             w_cross_hit;
    logic             n_hit;
    logic             r_hit;

    assign w_coord[C_A0X] = i_first_start_x;
    assign w_coord[C_A0Y] = i_first_start_y;
    assign w_coord[C_A1X] = i_first_end_x;
    assign w_coord[C_A1Y] = i_first_end_y;
    assign w_coord[C_B0X] = i_second_start_x;
    assign w_coord[C_B0Y] = i_second_start_y;
    assign w_coord[C_B1X] = i_second_end_x;
    assign w_coord[C_B1Y] = i_second_end_y;

    // a stage loads when it is empty or its successor loads
    always_comb begin
        w_en[N_STG-1] = !r_vld[N_STG-1] || !i_stall;
        for (int k = N_STG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld[0] = w_en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < N_STG; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    sit_diff #(.CW(CW)) u_diff (
        .i_clk   (i_clk),
        .i_en    (w_en[0]),
        .i_coord (w_coord),
        .o_diff  (w_diff),
        .o_box   (w_box1)
    );

    sit_mul #(.CW(CW)) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_en[1]),
        .i_diff (w_diff),
        .i_box  (w_box1),
        .o_prod (w_prod),
        .o_box  (w_box2)
    );

    sit_sign #(.CW(CW)) u_sign (
        .i_clk  (i_clk),
        .i_en   (w_en[2]),
        .i_prod (w_prod),
        .i_box  (w_box2),
        .o_sgn  (w_sgn),
        .o_box  (w_box3)
    );

    always_comb begin
        w_par_hit   = (w_sgn[X_C1].zero && w_box3.b0_on_a) ||
                      (w_sgn[X_C2].zero && w_box3.b1_on_a) ||
                      (w_sgn[X_C3].zero && w_box3.a0_on_b) ||
                      (w_sgn[X_C4].zero && w_box3.a1_on_b);
        w_cross_hit = !w_sgn[X_C1].zero && !w_sgn[X_C2].zero &&
                      (w_sgn[X_C1].neg ^ w_sgn[X_C2].neg) &&
                      !w_sgn[X_C3].zero && !w_sgn[X_C4].zero &&
                      (w_sgn[X_C3].neg ^ w_sgn[X_C4].neg);
        n_hit       = w_sgn[X_DIR].zero ? w_par_hit : w_cross_hit;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[N_STG-1]) begin
            r_hit <= n_hit;
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[N_STG-1];
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

/* hdl/sit_chk.sv */
`default_nettype none

module sit_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_hit
);

    // an empty output slot means the whole pipe can move
    a_no_stall_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall
    ) else $error("input stalled while output slot is empty");

    a_empty_after_reset: assert property (
        @(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid
    ) else $error("result presented right after reset");

    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hit))
    ) else $error("stalled result dropped or changed");

    a_stall_needs_backpressure: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (i_stall && o_valid)
    ) else $error("input stalled without output backpressure");

endmodule

bind segment_intersection_test_unit sit_chk u_sit_chk (.*);

`default_nettype wire

/* tb/tb_segment_intersection_test_unit.sv */
`timescale 1ns / 1ps

typedef struct packed {
    logic [sit_pkg::SIT_FIELD_W-1:0] a0x;
    logic [sit_pkg::SIT_FIELD_W-1:0] a0y;
    logic [sit_pkg::SIT_FIELD_W-1:0] a1x;
    logic [sit_pkg::SIT_FIELD_W-1:0] a1y;
    logic [sit_pkg::SIT_FIELD_W-1:0] b0x;
    logic [sit_pkg::SIT_FIELD_W-1:0] b0y;
    logic [sit_pkg::SIT_FIELD_W-1:0] b1x;
    logic [sit_pkg::SIT_FIELD_W-1:0] b1y;
} seg_pair_t;

module tb_segment_intersection_test_unit;
    import sit_pkg::*;

    localparam int COORD_W     = 16;
    localparam int N_RANDOM    = 1300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 80;

    class hit_board;
        bit expected_hits[$];
        int errors;

        function longint coord(logic [sit_pkg::SIT_FIELD_W-1:0] raw);
            logic signed [COORD_W-1:0] v;
            v = raw[COORD_W-1:0];
            return longint'(v);
        endfunction

        function longint orient(longint ox, longint oy, longint ax, longint ay,
                                longint bx, longint by);
            return (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
        endfunction

        function bit on_seg(longint s0x, longint s0y, longint s1x, longint s1y,
                            longint px, longint py);
            if (orient(s0x, s0y, s1x, s1y, px, py) != 0)
                return 1'b0;
            return px >= (s0x < s1x ? s0x : s1x) && px <= (s0x > s1x ? s0x : s1x) &&
                   py >= (s0y < s1y ? s0y : s1y) && py <= (s0y > s1y ? s0y : s1y);
        endfunction

        function bit opposite(longint c1, longint c2);
            return (c1 > 0 && c2 < 0) || (c1 < 0 && c2 > 0);
        endfunction

        function bit segments_cross(seg_pair_t p);
            longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
            ax0 = coord(p.a0x); ay0 = coord(p.a0y);
            ax1 = coord(p.a1x); ay1 = coord(p.a1y);
            bx0 = coord(p.b0x); by0 = coord(p.b0y);
            bx1 = coord(p.b1x); by1 = coord(p.b1y);
            if ((ax1 - ax0) * (by1 - by0) - (ay1 - ay0) * (bx1 - bx0) == 0)
                return on_seg(ax0, ay0, ax1, ay1, bx0, by0) ||
                       on_seg(ax0, ay0, ax1, ay1, bx1, by1) ||
                       on_seg(bx0, by0, bx1, by1, ax0, ay0) ||
                       on_seg(bx0, by0, bx1, by1, ax1, ay1);
            return opposite(orient(ax0, ay0, ax1, ay1, bx0, by0),
                            orient(ax0, ay0, ax1, ay1, bx1, by1)) &&
                   opposite(orient(bx0, by0, bx1, by1, ax0, ay0),
                            orient(bx0, by0, bx1, by1, ax1, ay1));
        endfunction

        function void note_pair(seg_pair_t p);
            expected_hits.push_back(segments_cross(p));
        endfunction

        function void check_hit(logic actual);
            bit want;
            if (expected_hits.size() == 0) begin
                $error("hit: no result expected, actual %0b", actual);
                errors++;
                return;
            end
            want = expected_hits.pop_front();
            if (actual !== want) begin
                $error("hit: expected %0b, actual %0b", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [SIT_FIELD_W-1:0] i_first_start_x = '0;
    logic [SIT_FIELD_W-1:0] i_first_start_y = '0;
    logic [SIT_FIELD_W-1:0] i_first_end_x = '0;
    logic [SIT_FIELD_W-1:0] i_first_end_y = '0;
    logic [SIT_FIELD_W-1:0] i_second_start_x = '0;
    logic [SIT_FIELD_W-1:0] i_second_start_y = '0;
    logic [SIT_FIELD_W-1:0] i_second_end_x = '0;
    logic [SIT_FIELD_W-1:0] i_second_end_y = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic                   o_hit;

    hit_board board;
    int  pairs_in = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    bit  hold_on = 1'b0;

    segment_intersection_test_unit #(
        .COORD_WIDTH(COORD_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_first_start_x (i_first_start_x),
        .i_first_start_y (i_first_start_y),
        .i_first_end_x   (i_first_end_x),
        .i_first_end_y   (i_first_end_y),
        .i_second_start_x(i_second_start_x),
        .i_second_start_y(i_second_start_y),
        .i_second_end_x  (i_second_end_x),
        .i_second_end_y  (i_second_end_y),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // input and output transfer monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            board.note_pair({i_first_start_x, i_first_start_y, i_first_end_x, i_first_end_y,
                             i_second_start_x, i_second_start_y, i_second_end_x,
                             i_second_end_y});
            pairs_in <= pairs_in + 1;
        end
        if (i_rst_n && o_valid && !i_stall)
            board.check_hit(o_hit);
    end

    // receiver: random stalls, plus one long hold to back up the pipe
    initial begin
        int r;
        int n;
        bit held;
        held = 1'b0;
        forever begin
            if (!held && i_rst_n && pairs_in >= 40) begin
                held = 1'b1;
                hold_on = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on = 1'b0;
            end else begin
                r = $urandom_range(99);
                if (r < 45) begin
                    i_stall <= 1'b0;
                    n = $urandom_range(8, 1);
                end else if (r < 55) begin
                    i_stall <= 1'b0;
                    n = $urandom_range(60, 30);
                end else if (r < 92) begin
                    i_stall <= 1'b1;
                    n = $urandom_range(3, 1);
                end else begin
                    i_stall <= 1'b1;
                    n = $urandom_range(30, 10);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    function int next_gap();
        int r;
        if (hold_on)
            return 0;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 4) begin
            burst_left = 40;
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(25, 8);
    endfunction

    task automatic send_pair(input seg_pair_t p);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_first_start_x  <= p.a0x;
        i_first_start_y  <= p.a0y;
        i_first_end_x    <= p.a1x;
        i_first_end_y    <= p.a1y;
        i_second_start_x <= p.b0x;
        i_second_start_y <= p.b0y;
        i_second_end_x   <= p.b1x;
        i_second_end_y   <= p.b1y;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic send_ints(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
        seg_pair_t p;
        p.a0x = ax0[15:0]; p.a0y = ay0[15:0];
        p.a1x = ax1[15:0]; p.a1y = ay1[15:0];
        p.b0x = bx0[15:0]; p.b0y = by0[15:0];
        p.b1x = bx1[15:0]; p.b1y = by1[15:0];
        send_pair(p);
    endtask

    function int pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function int edge_value();
        case ($urandom_range(6))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            default: return 32767;
        endcase
    endfunction

    task automatic send_random();
        seg_pair_t p;
        int r, px, py, dx, dy, ox, oy, t0, t1, t2, t3;
        r = $urandom_range(99);
        if (r < 35) begin
            p = {$urandom, $urandom, $urandom, $urandom};
            send_pair(p);
        end else if (r < 60) begin
            send_ints(pick(-8, 8), pick(-8, 8), pick(-8, 8), pick(-8, 8),
                      pick(-8, 8), pick(-8, 8), pick(-8, 8), pick(-8, 8));
        end else if (r < 80) begin
            // points on one line, second segment sometimes shifted off it
            px = pick(-1000, 1000); py = pick(-1000, 1000);
            dx = pick(-20, 20);     dy = pick(-20, 20);
            t0 = pick(-6, 6); t1 = pick(-6, 6); t2 = pick(-6, 6); t3 = pick(-6, 6);
            ox = 0; oy = 0;
            if ($urandom_range(2) == 0) begin
                ox = pick(-3, 3);
                oy = pick(-3, 3);
            end
            send_ints(px + t0 * dx, py + t0 * dy, px + t1 * dx, py + t1 * dy,
                      px + t2 * dx + ox, py + t2 * dy + oy,
                      px + t3 * dx + ox, py + t3 * dy + oy);
        end else if (r < 90) begin
            send_ints(edge_value(), edge_value(), edge_value(), edge_value(),
                      edge_value(), edge_value(), edge_value(), edge_value());
        end else begin
            // shared endpoint
            p = {$urandom, $urandom, $urandom, $urandom};
            if ($urandom_range(1)) begin
                p.b0x = p.a1x;
                p.b0y = p.a1y;
            end else begin
                p.b1x = p.a0x;
                p.b1y = p.a0y;
            end
            send_pair(p);
        end
    endtask

    initial begin
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_ints(0, 0, 10, 10, 0, 10, 10, 0);
        send_ints(0, 0, 10, 10, 10, 10, 20, 0);
        send_ints(0, 0, 10, 0, 5, 0, 5, 10);
        send_ints(0, 0, 10, 0, 0, 1, 10, 1);
        send_ints(0, 0, 10, 0, 5, 0, 15, 0);
        send_ints(0, 0, 10, 0, 10, 0, 20, 0);
        send_ints(0, 0, 10, 0, 11, 0, 20, 0);
        send_ints(2, 2, 3, 3, 0, 0, 10, 10);
        send_ints(0, 0, 10, 10, 3, 3, 2, 2);
        send_ints(5, 5, 5, 5, 0, 0, 10, 10);
        send_ints(5, 6, 5, 6, 0, 0, 10, 10);
        send_ints(7, -3, 7, -3, 7, -3, 7, -3);
        send_ints(7, -3, 7, -3, 8, -3, 8, -3);
        send_ints(20, 20, 20, 20, 0, 0, 10, 10);
        send_ints(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_ints(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_ints(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_ints(-32768, 0, 32767, 0, 0, 0, 32767, 0);
        send_ints(-32768, -32767, 32767, 32767, -32767, -32768, 32767, 32766);
        send_ints(10, 0, 0, 0, 5, 0, 3, 0);
        send_ints(0, 0, 0, 0, 0, 0, 0, 0);
        send_ints(-5, 3, 4, -6, -5, -6, 4, 3);
        send_ints(32767, -32768, -32768, 32767, 0, 0, -1, -1);

        repeat (N_RANDOM) send_random();
        i_valid <= 1'b0;
        @(posedge i_clk);

        while (board.expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* files.f */
hdl/sit_pkg.sv
hdl/sit_diff.sv
hdl/sit_mul.sv
hdl/sit_sign.sv
hdl/segment_intersection_test_unit.sv
hdl/sit_chk.sv
tb/tb_segment_intersection_test_unit.sv
